/* design/qau_pkg.sv */
package qau_pkg;

	// component format, Q2.13 in 16 bits
	localparam int CW = 16;
	localparam int FW = 13;
	localparam int CMD_W = 3;

	// product, sum and square-root widths
	localparam int PW = 2 * CW;          // one signed product
	localparam int SW = PW + 2;          // sum of four products plus rounding
	localparam int SQW = PW + 1;         // sum of four squares
	localparam int RTW = CW + 1;         // integer square root of that sum
	localparam int SQ_N = CW + 1;        // square-root iterations, one per stage
	localparam int QW = FW + 1;          // normalized magnitude, at most 1.0
	localparam int NW = CW + FW;         // divider dividend
	localparam int RW = RTW + 1;         // divider partial remainder

	localparam int S_TDATA_W = ((CMD_W + 8 * CW + 7) / 8) * 8;
	localparam int M_TDATA_W = ((4 * CW + 2 + 7) / 8) * 8;

	typedef logic signed [CW-1:0] comp_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_MUL   = 3'd0,
		CMD_ADD   = 3'd1,
		CMD_SUB   = 3'd2,
		CMD_SCALE = 3'd3,
		CMD_NORM  = 3'd4,
		CMD_ROT   = 3'd5
	} cmd_t;

	// what travels alongside the normalize pipe
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		comp_t [3:0]      a;
		comp_t [3:0]      r;
		logic             sat;
	} pay_t;

	localparam comp_t COMP_MAX = comp_t'((1 << (CW - 1)) - 1);
	localparam comp_t COMP_MIN = comp_t'(1 << (CW - 1));
	localparam comp_t COMP_ONE = comp_t'(1 << FW);

	// saturate to the component range: {clipped, value}
	function automatic logic [CW:0] clip(input logic signed [SW-1:0] v);
		logic [CW:0] res;
		if (v > SW'(COMP_MAX)) begin
			res = {1'b1, COMP_MAX};
		end else if (v < SW'(COMP_MIN)) begin
			res = {1'b1, COMP_MIN};
		end else begin
			res = {1'b0, v[CW-1:0]};
		end
		return res;
	endfunction

	// divide by 2^FW, nearest, ties toward +inf
	function automatic logic signed [SW-1:0] rnd(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] t;
		t = v + SW'(1 << (FW - 1));
		return t >>> FW;
	endfunction

endpackage

/* design/qau_norm.sv */
module qau_norm (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  qau_pkg::pay_t              in_pay,
	input  logic [qau_pkg::SQW-1:0]    in_ssq,
	output logic                       out_vld,
	output qau_pkg::pay_t              out_pay,
	output qau_pkg::comp_t [3:0]       out_q,
	output logic                       out_zero
);
	import qau_pkg::*;

	// square root, one result bit per stage
	logic           sq_vld [0:SQ_N];
	pay_t           sq_pay [0:SQ_N];
	logic [SQW-1:0] sq_v   [0:SQ_N];
	logic [SQW:0]   sq_res [0:SQ_N];

	assign sq_vld[0] = in_vld;
	assign sq_pay[0] = in_pay;
	assign sq_v[0]   = in_ssq;
	assign sq_res[0] = '0;

	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		localparam logic [SQW:0] SQBIT = (SQW + 1)'(1) << (2 * (SQ_N - 1 - k));
		logic [SQW:0] t;
		logic         ge;
		assign t  = sq_res[k] + SQBIT;
		assign ge = {1'b0, sq_v[k]} >= t;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld[k+1] <= 1'b0;
			end else if (en) begin
				sq_vld[k+1] <= sq_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_pay[k+1] <= sq_pay[k];
				if (ge) begin
					sq_v[k+1]   <= SQW'({1'b0, sq_v[k]} - t);
					sq_res[k+1] <= (sq_res[k] >> 1) + SQBIT;
				end else begin
					sq_v[k+1]   <= sq_v[k];
					sq_res[k+1] <= sq_res[k] >> 1;
				end
			end
		end
	end

	// dividend set-up: (|a| << FW) + m/2
	logic [RTW-1:0] mag_root;
	logic [NW-1:0]  dvd [4];

	assign mag_root = sq_res[SQ_N][RTW-1:0];

	always_comb begin
		logic [CW-1:0] mag;
		for (int i = 0; i < 4; i++) begin
			mag = sq_pay[SQ_N].a[i][CW-1] ? CW'(-sq_pay[SQ_N].a[i]) : CW'(sq_pay[SQ_N].a[i]);
			dvd[i] = (NW'(mag) << FW) + NW'(mag_root >> 1);
		end
	end

	// restoring divider, one quotient bit per stage, four lanes
	logic           dv_vld  [0:QW];
	pay_t           dv_pay  [0:QW];
	logic [RTW-1:0] dv_m    [0:QW];
	logic           dv_zero [0:QW];
	logic [NW-1:0]  dv_n    [0:QW][4];
	logic [RW-1:0]  dv_rem  [0:QW][4];
	logic [QW-1:0]  dv_q    [0:QW][4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld[0] <= 1'b0;
		end else if (en) begin
			dv_vld[0] <= sq_vld[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_pay[0]  <= sq_pay[SQ_N];
			dv_m[0]    <= mag_root;
			dv_zero[0] <= mag_root == '0;
			for (int i = 0; i < 4; i++) begin
				dv_n[0][i]   <= dvd[i];
				dv_rem[0][i] <= RW'(dvd[i] >> QW);
				dv_q[0][i]   <= '0;
			end
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[j+1] <= 1'b0;
			end else if (en) begin
				dv_vld[j+1] <= dv_vld[j];
			end
		end

		always_ff @(posedge clk) begin
			logic [RW-1:0] t;
			logic          ge;
			if (en) begin
				dv_pay[j+1]  <= dv_pay[j];
				dv_m[j+1]    <= dv_m[j];
				dv_zero[j+1] <= dv_zero[j];
				for (int i = 0; i < 4; i++) begin
					t  = {dv_rem[j][i][RW-2:0], dv_n[j][i][QW-1-j]};
					ge = t >= RW'(dv_m[j]);
					dv_n[j+1][i]   <= dv_n[j][i];
					dv_rem[j+1][i] <= ge ? RW'(t - RW'(dv_m[j])) : t;
					dv_q[j+1][i]   <= {dv_q[j][i][QW-2:0], ge};
				end
			end
		end
	end

	assign out_vld  = dv_vld[QW];
	assign out_pay  = dv_pay[QW];
	assign out_zero = dv_zero[QW];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (dv_zero[QW]) begin
				out_q[i] = (i == 0) ? COMP_ONE : '0;
			end else if (dv_pay[QW].a[i][CW-1]) begin
				out_q[i] = comp_t'(-CW'(dv_q[QW][i]));
			end else begin
				out_q[i] = comp_t'(CW'(dv_q[QW][i]));
			end
		end
	end

endmodule

/* design/quaternion_arithmetic_unit.sv */
// Quaternion arithmetic unit: each input transfer carries an opcode and two
// Q2.13 quaternions A and B and yields exactly one result transfer. Opcodes:
// Hamilton product A*B, add, subtract, scale of A by b_w, normalize A, and
// rotate (A times the pure quaternion (0, b_x, b_y, b_z)); other codes pass
// A through. Product sums are exact and rounded once to nearest (ties up),
// then every component saturates, raising `saturated`. Normalize uses the
// integer square root of the sum of squares and rounds each quotient half
// away from zero; an all-zero A returns (1,0,0,0) with `zero_magnitude` set.
// Throughput is one transfer per clock while the result side accepts. Every
// opcode passes the same stages from input to output: two stages for products
// and sums, 17 square-root stages (one root bit each), one dividend stage, 14
// divider stages (one quotient bit each) and the output register. The whole pipe
// moves together; a stall on the result side holds every stage in place.
module quaternion_arithmetic_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// cmd, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z; zero padded
	input  logic [qau_pkg::S_TDATA_W-1:0]     s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// r_w, r_x, r_y, r_z, saturated, zero_magnitude; zero padded
	output logic [qau_pkg::M_TDATA_W-1:0]     m_tdata
);
	import qau_pkg::*;

	// global advance: output register empty or being drained
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// unpack input transfer
	logic [CMD_W-1:0] cmd_in;
	comp_t            a_in [4];
	comp_t            b_in [4];
	comp_t            bm   [4];

	always_comb begin
		cmd_in = s_tdata[CMD_W-1:0];
		for (int i = 0; i < 4; i++) begin
			a_in[i] = s_tdata[CMD_W + CW*i +: CW];
			b_in[i] = s_tdata[CMD_W + CW*(4+i) +: CW];
			bm[i]   = b_in[i];
		end
		// rotate multiplies by a pure quaternion
		if (cmd_t'(cmd_in) == CMD_ROT) begin
			bm[0] = '0;
		end
	end

	// stage 1: all sixteen cross products and the four squares
	logic                  vld_s1;
	logic [CMD_W-1:0]      cmd_s1;
	comp_t                 a_s1 [4];
	comp_t                 b_s1 [4];
	logic signed [PW-1:0]  p_s1 [4][4];
	logic [PW-1:0]         sq_s1 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= cmd_in;
			for (int i = 0; i < 4; i++) begin
				a_s1[i]  <= a_in[i];
				b_s1[i]  <= b_in[i];
				sq_s1[i] <= PW'(a_in[i] * a_in[i]);
				for (int j = 0; j < 4; j++) begin
					p_s1[i][j] <= a_in[i] * bm[j];
				end
			end
		end
	end

	// stage 2: sums, rounding, saturation; sum of squares for normalize
	logic signed [SW-1:0] e [4][4];
	logic signed [SW-1:0] pre [4];
	logic                 pre_rounded;
	pay_t                 pay_c;
	logic [SQW-1:0]       ssq_c;

	always_comb begin
		logic [CW:0] c;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				e[i][j] = SW'(p_s1[i][j]);
			end
		end
		pre_rounded = 1'b0;
		for (int i = 0; i < 4; i++) begin
			pre[i] = SW'(a_s1[i]);
		end
		case (cmd_t'(cmd_s1))
			CMD_MUL, CMD_ROT: begin
				pre[0] = rnd(e[0][0] - e[1][1] - e[2][2] - e[3][3]);
				pre[1] = rnd(e[0][1] + e[1][0] + e[2][3] - e[3][2]);
				pre[2] = rnd(e[0][2] - e[1][3] + e[2][0] + e[3][1]);
				pre[3] = rnd(e[0][3] + e[1][2] - e[2][1] + e[3][0]);
				pre_rounded = 1'b1;
			end
			CMD_ADD: begin
				for (int i = 0; i < 4; i++) begin
					pre[i] = SW'(a_s1[i]) + SW'(b_s1[i]);
				end
			end
			CMD_SUB: begin
				for (int i = 0; i < 4; i++) begin
					pre[i] = SW'(a_s1[i]) - SW'(b_s1[i]);
				end
			end
			CMD_SCALE: begin
				for (int i = 0; i < 4; i++) begin
					pre[i] = rnd(e[i][0]);
				end
			end
			default: begin
				// normalize and undefined codes keep A here
			end
		endcase

		pay_c.cmd = cmd_s1;
		pay_c.sat = 1'b0;
		for (int i = 0; i < 4; i++) begin
			pay_c.a[i] = a_s1[i];
			c          = clip(pre[i]);
			pay_c.r[i] = c[CW-1:0];
			pay_c.sat  = pay_c.sat | c[CW];
		end

		ssq_c = SQW'(sq_s1[0]) + SQW'(sq_s1[1]) + SQW'(sq_s1[2]) + SQW'(sq_s1[3]);
	end

	logic           vld_s2;
	pay_t           pay_s2;
	logic [SQW-1:0] ssq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s2 <= pay_c;
			ssq_s2 <= ssq_c;
		end
	end

	// square root and divide; every opcode rides the same pipe
	logic        nrm_vld;
	pay_t        nrm_pay;
	comp_t [3:0] nrm_q;
	logic        nrm_zero;

	qau_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.in_pay   (pay_s2),
		.in_ssq   (ssq_s2),
		.out_vld  (nrm_vld),
		.out_pay  (nrm_pay),
		.out_q    (nrm_q),
		.out_zero (nrm_zero)
	);

	// output register
	logic [M_TDATA_W-1:0] out_c;
	logic [M_TDATA_W-1:0] tdata_q;
	logic                 tvalid_q;

	always_comb begin
		out_c = '0;
		if (cmd_t'(nrm_pay.cmd) == CMD_NORM) begin
			for (int i = 0; i < 4; i++) begin
				out_c[CW*i +: CW] = nrm_q[i];
			end
			out_c[4*CW+1] = nrm_zero;
		end else begin
			for (int i = 0; i < 4; i++) begin
				out_c[CW*i +: CW] = nrm_pay.r[i];
			end
			out_c[4*CW] = nrm_pay.sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (en) begin
			tvalid_q <= nrm_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tdata_q <= out_c;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;

endmodule
